@@ sv/skt_pkg.sv @@
package skt_pkg;

    // table geometry
    localparam int CAPACITY  = 64;
    localparam int KEY_WIDTH = 32;
    localparam int ADDR_W    = $clog2(CAPACITY);
    localparam int CNT_W     = $clog2(CAPACITY + 1);

    typedef enum logic [1:0] {
        CMD_INSERT     = 2'd0,
        CMD_REMOVE_KEY = 2'd1,
        CMD_REMOVE_AT  = 2'd2,
        CMD_CLEAR      = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_FULL      = 2'd1,
        STATUS_NOT_FOUND = 2'd2,
        STATUS_BAD_INDEX = 2'd3
    } status_t;

    typedef struct packed {
        cmd_t                  command;
        logic [KEY_WIDTH-1:0]  key;
        logic [ADDR_W-1:0]     index;
    } req_item_t;

    typedef struct packed {
        status_t               status;
        logic [CNT_W-1:0]      position;
        logic [CNT_W-1:0]      removed_count;
        logic [CNT_W-1:0]      entry_count;
    } rsp_item_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_BS_HI,
        S_BS_HI_CMP,
        S_BS_LO,
        S_BS_LO_CMP,
        S_BS_MID,
        S_BS_MID_CMP,
        S_UP_RD,
        S_UP_WR,
        S_PUT,
        S_SCAN_RD,
        S_SCAN_CMP,
        S_RUN_RD,
        S_RUN_CMP,
        S_DN_RD,
        S_DN_WR,
        S_DONE
    } state_t;

endpackage

@@ sv/skt_channels.sv @@
interface skt_req_if;
    logic                valid;
    logic                ready;
    skt_pkg::req_item_t  item;

    modport source (output valid, output item, input ready);
    modport sink   (input valid, input item, output ready);
endinterface

interface skt_rsp_if;
    logic                valid;
    logic                ready;
    skt_pkg::rsp_item_t  item;

    modport source (output valid, output item, input ready);
    modport sink   (input valid, input item, output ready);
endinterface

@@ sv/sorted_key_table.sv @@
// channel    dir   payload
// request    in    command, key, index
// response   out   status, position, removed_count, entry_count
//
// one command at a time: a sequencer, a table memory with one read and one write port and registered reads
// and one key comparator; request ready only while idle.
// insert: a binary search for the slot, then each key at or above it shifted up, then the write.
// remove key: a linear scan for the first copy, a count of the run of equal copies, then each later
// key shifted down (an absent key ends after the scan); remove at index: the shift down; others: none.
// reset empties the table at once; a result not yet taken holds the last state and stalls requests.
module sorted_key_table (
    input  logic     clk,
    input  logic     rst_n,
    skt_req_if.sink  request,
    skt_rsp_if.source response
);

    skt_pkg::state_t                    state_reg, state_next;
    logic [skt_pkg::KEY_WIDTH-1:0]      key_reg, key_next;
    logic [skt_pkg::CNT_W-1:0]          fill_reg, fill_next;
    logic [skt_pkg::ADDR_W-1:0]         lo_reg, lo_next;
    logic [skt_pkg::ADDR_W-1:0]         hi_reg, hi_next;
    logic [skt_pkg::CNT_W-1:0]          ptr_reg, ptr_next;
    logic [skt_pkg::CNT_W-1:0]          pos_reg, pos_next;
    logic [skt_pkg::CNT_W-1:0]          cnt_reg, cnt_next;
    logic [skt_pkg::CNT_W-1:0]          removed_reg, removed_next;
    skt_pkg::status_t                   status_reg, status_next;
    logic                               out_valid_reg, out_valid_next;
    skt_pkg::rsp_item_t                 out_item_reg, out_item_next;

    // table memory
    logic [skt_pkg::KEY_WIDTH-1:0]      mem [skt_pkg::CAPACITY];
    logic [skt_pkg::KEY_WIDTH-1:0]      rd_data_reg;
    logic [skt_pkg::ADDR_W-1:0]         mem_rd_addr;
    logic                               mem_we;
    logic [skt_pkg::ADDR_W-1:0]         mem_wr_addr;
    logic [skt_pkg::KEY_WIDTH-1:0]      mem_wr_data;

    // shared address arithmetic
    logic [skt_pkg::ADDR_W-1:0]         mid;
    logic [skt_pkg::CNT_W:0]            run_end;
    logic [skt_pkg::CNT_W:0]            src_addr;
    logic [skt_pkg::CNT_W-1:0]          idx_ext;
    logic                               load_rsp;

    // shared key comparator
    logic                               key_lt;
    logic                               key_eq;

    assign mid      = skt_pkg::ADDR_W'(({1'b0, lo_reg} + {1'b0, hi_reg}) >> 1);
    assign run_end  = {1'b0, pos_reg} + {1'b0, cnt_reg};
    assign src_addr = {1'b0, ptr_reg} + {1'b0, cnt_reg};
    assign idx_ext  = skt_pkg::CNT_W'(request.item.index);
    assign load_rsp = (state_reg == skt_pkg::S_DONE) && (!out_valid_reg || response.ready);

    assign key_lt   = (rd_data_reg < key_reg);
    assign key_eq   = (rd_data_reg == key_reg);

    assign request.ready  = (state_reg == skt_pkg::S_IDLE);
    assign response.valid = out_valid_reg;
    assign response.item  = out_item_reg;

    // memory port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wr_addr] <= mem_wr_data;
        end
        rd_data_reg <= mem[mem_rd_addr];
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            skt_pkg::S_IDLE:
            begin
                if (request.valid)
                begin
                    unique case (request.item.command)
                        skt_pkg::CMD_INSERT:
                        begin
                            if (fill_reg >= skt_pkg::CNT_W'(skt_pkg::CAPACITY))
                                state_next = skt_pkg::S_DONE;
                            else if (fill_reg == '0)
                                state_next = skt_pkg::S_PUT;
                            else
                                state_next = skt_pkg::S_BS_HI;
                        end
                        skt_pkg::CMD_REMOVE_KEY:
                            state_next = skt_pkg::S_SCAN_RD;
                        skt_pkg::CMD_REMOVE_AT:
                        begin
                            if (idx_ext >= fill_reg)
                                state_next = skt_pkg::S_DONE;
                            else
                                state_next = skt_pkg::S_DN_RD;
                        end
                        skt_pkg::CMD_CLEAR:
                            state_next = skt_pkg::S_DONE;
                        default:
                            state_next = skt_pkg::S_DONE;
                    endcase
                end
            end
            skt_pkg::S_BS_HI:
                state_next = skt_pkg::S_BS_HI_CMP;
            skt_pkg::S_BS_HI_CMP:
                state_next = (key_lt || key_eq) ? skt_pkg::S_UP_RD : skt_pkg::S_BS_LO;
            skt_pkg::S_BS_LO:
                state_next = skt_pkg::S_BS_LO_CMP;
            skt_pkg::S_BS_LO_CMP:
                state_next = (!key_lt) ? skt_pkg::S_UP_RD : skt_pkg::S_BS_MID;
            skt_pkg::S_BS_MID:
                state_next = skt_pkg::S_BS_MID_CMP;
            skt_pkg::S_BS_MID_CMP:
                state_next = skt_pkg::S_BS_HI;
            skt_pkg::S_UP_RD:
                state_next = (ptr_reg > pos_reg) ? skt_pkg::S_UP_WR : skt_pkg::S_PUT;
            skt_pkg::S_UP_WR:
                state_next = skt_pkg::S_UP_RD;
            skt_pkg::S_PUT:
                state_next = skt_pkg::S_DONE;
            skt_pkg::S_SCAN_RD:
                state_next = (ptr_reg >= fill_reg) ? skt_pkg::S_DONE : skt_pkg::S_SCAN_CMP;
            skt_pkg::S_SCAN_CMP:
                state_next = key_eq ? skt_pkg::S_RUN_RD : skt_pkg::S_SCAN_RD;
            skt_pkg::S_RUN_RD:
                state_next = (run_end >= {1'b0, fill_reg}) ? skt_pkg::S_DN_RD
                                                          : skt_pkg::S_RUN_CMP;
            skt_pkg::S_RUN_CMP:
                state_next = key_eq ? skt_pkg::S_RUN_RD : skt_pkg::S_DN_RD;
            skt_pkg::S_DN_RD:
                state_next = (src_addr < {1'b0, fill_reg}) ? skt_pkg::S_DN_WR : skt_pkg::S_DONE;
            skt_pkg::S_DN_WR:
                state_next = skt_pkg::S_DN_RD;
            skt_pkg::S_DONE:
                state_next = load_rsp ? skt_pkg::S_IDLE : skt_pkg::S_DONE;
            default:
                state_next = skt_pkg::S_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb
    begin
        key_next       = key_reg;
        fill_next      = fill_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        ptr_next       = ptr_reg;
        pos_next       = pos_reg;
        cnt_next       = cnt_reg;
        removed_next   = removed_reg;
        status_next    = status_reg;
        out_valid_next = out_valid_reg && !response.ready;
        out_item_next  = out_item_reg;
        mem_rd_addr    = '0;
        mem_we         = 1'b0;
        mem_wr_addr    = '0;
        mem_wr_data    = key_reg;

        unique case (state_reg)
            skt_pkg::S_IDLE:
            begin
                if (request.valid)
                begin
                    key_next     = request.item.key;
                    status_next  = skt_pkg::STATUS_OK;
                    pos_next     = '0;
                    removed_next = '0;
                    cnt_next     = '0;
                    ptr_next     = '0;
                    lo_next      = '0;
                    hi_next      = skt_pkg::ADDR_W'(fill_reg - 1'b1);
                    unique case (request.item.command)
                        skt_pkg::CMD_INSERT:
                        begin
                            if (fill_reg >= skt_pkg::CNT_W'(skt_pkg::CAPACITY))
                                status_next = skt_pkg::STATUS_FULL;
                        end
                        skt_pkg::CMD_REMOVE_KEY:
                        begin
                        end
                        skt_pkg::CMD_REMOVE_AT:
                        begin
                            if (idx_ext >= fill_reg)
                            begin
                                status_next = skt_pkg::STATUS_BAD_INDEX;
                            end
                            else
                            begin
                                pos_next     = idx_ext;
                                ptr_next     = idx_ext;
                                cnt_next     = skt_pkg::CNT_W'(1);
                                removed_next = skt_pkg::CNT_W'(1);
                            end
                        end
                        skt_pkg::CMD_CLEAR:
                        begin
                            removed_next = fill_reg;
                            fill_next    = '0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            // binary search for the insert slot
            skt_pkg::S_BS_HI:
                mem_rd_addr = hi_reg;
            skt_pkg::S_BS_HI_CMP:
            begin
                if (key_lt || key_eq)
                begin
                    pos_next = skt_pkg::CNT_W'({1'b0, hi_reg} + 1'b1);
                    ptr_next = fill_reg;
                end
            end
            skt_pkg::S_BS_LO:
                mem_rd_addr = lo_reg;
            skt_pkg::S_BS_LO_CMP:
            begin
                if (!key_lt)
                begin
                    pos_next = skt_pkg::CNT_W'(lo_reg);
                    ptr_next = fill_reg;
                end
            end
            skt_pkg::S_BS_MID:
                mem_rd_addr = mid;
            skt_pkg::S_BS_MID_CMP:
            begin
                if (key_lt || key_eq)
                    lo_next = mid + 1'b1;
                else
                    hi_next = mid;
            end
            // open a slot by moving the keys at and above it up
            skt_pkg::S_UP_RD:
                mem_rd_addr = skt_pkg::ADDR_W'(ptr_reg - 1'b1);
            skt_pkg::S_UP_WR:
            begin
                mem_we      = 1'b1;
                mem_wr_addr = skt_pkg::ADDR_W'(ptr_reg);
                mem_wr_data = rd_data_reg;
                ptr_next    = ptr_reg - 1'b1;
            end
            skt_pkg::S_PUT:
            begin
                mem_we      = 1'b1;
                mem_wr_addr = skt_pkg::ADDR_W'(pos_reg);
                mem_wr_data = key_reg;
                fill_next   = fill_reg + 1'b1;
            end
            // linear scan for the first copy
            skt_pkg::S_SCAN_RD:
            begin
                mem_rd_addr = skt_pkg::ADDR_W'(ptr_reg);
                if (ptr_reg >= fill_reg)
                    status_next = skt_pkg::STATUS_NOT_FOUND;
            end
            skt_pkg::S_SCAN_CMP:
            begin
                if (key_eq)
                begin
                    pos_next = ptr_reg;
                    cnt_next = skt_pkg::CNT_W'(1);
                end
                else
                begin
                    ptr_next = ptr_reg + 1'b1;
                end
            end
            // count the run of equal keys
            skt_pkg::S_RUN_RD:
            begin
                mem_rd_addr = skt_pkg::ADDR_W'(run_end);
                if (run_end >= {1'b0, fill_reg})
                begin
                    removed_next = cnt_reg;
                    ptr_next     = pos_reg;
                end
            end
            skt_pkg::S_RUN_CMP:
            begin
                if (key_eq)
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
                else
                begin
                    removed_next = cnt_reg;
                    ptr_next     = pos_reg;
                end
            end
            // close the gap by moving later keys down
            skt_pkg::S_DN_RD:
            begin
                mem_rd_addr = skt_pkg::ADDR_W'(src_addr);
                if (src_addr >= {1'b0, fill_reg})
                    fill_next = fill_reg - cnt_reg;
            end
            skt_pkg::S_DN_WR:
            begin
                mem_we      = 1'b1;
                mem_wr_addr = skt_pkg::ADDR_W'(ptr_reg);
                mem_wr_data = rd_data_reg;
                ptr_next    = ptr_reg + 1'b1;
            end
            // hand the result to the output register
            skt_pkg::S_DONE:
            begin
                if (load_rsp)
                begin
                    out_valid_next              = 1'b1;
                    out_item_next.status        = status_reg;
                    out_item_next.position      = pos_reg;
                    out_item_next.removed_count = removed_reg;
                    out_item_next.entry_count   = fill_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    // registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= skt_pkg::S_IDLE;
            fill_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg      <= key_next;
        lo_reg       <= lo_next;
        hi_reg       <= hi_next;
        ptr_reg      <= ptr_next;
        pos_reg      <= pos_next;
        cnt_reg      <= cnt_next;
        removed_reg  <= removed_next;
        status_reg   <= status_next;
        out_item_reg <= out_item_next;
    end

`ifndef NO_ASSERTIONS
    // table never holds more than its capacity
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= skt_pkg::CNT_W'(skt_pkg::CAPACITY))
        else $error("fill count above capacity");

    // a full-table result reports a full count
    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (out_item_reg.status == skt_pkg::STATUS_FULL)
        |-> out_item_reg.entry_count == skt_pkg::CNT_W'(skt_pkg::CAPACITY))
        else $error("full status with table not full");

    // up-shift writes stay above the insert slot
    a_up_shift: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we && (state_reg == skt_pkg::S_UP_WR) |-> ptr_reg > pos_reg)
        else $error("up-shift write at or below insert slot");

    // a finished command with a free output register is delivered next cycle
    a_done_load: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == skt_pkg::S_DONE) && !out_valid_reg |=> out_valid_reg)
        else $error("result not loaded");
`endif

endmodule

@@ dv/sorted_table_checker.sv @@
module sorted_table_checker
    import skt_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    skt_req_if    request,
    skt_rsp_if    response,
    output int    fails,
    output int    pending,
    output int    checked,
    output int    full_hits,
    output int    miss_hits,
    output int    bad_index_hits,
    output int    peak_fill
);

    // an insert among equal keys may land anywhere in the equal run,
    // so the expected position is a range [want.position, pos_hi]
    typedef struct {
        rsp_item_t  want;
        int         pos_hi;
    } outcome_t;

    logic [KEY_WIDTH-1:0]  held_keys[$];
    outcome_t              awaited_results[$];
    outcome_t              head;

    task automatic report_mismatch(string msg);
        // keep the log short on a badly broken block, but count everything
        if (fails < 40)
            $display("[%0t] mismatch: %s", $time, msg);
        fails++;
    endtask

    // apply one command to the shadow table and return the expected result
    function automatic outcome_t apply_command(req_item_t rq);
        outcome_t  o;
        int        lo;
        int        hi;
        int        n;
        o.want = '0;
        o.want.status = STATUS_OK;
        o.pos_hi = -1;
        case (rq.command)
            CMD_INSERT:
            begin
                if (held_keys.size() >= CAPACITY)
                    o.want.status = STATUS_FULL;
                else
                begin
                    lo = 0;
                    while (lo < held_keys.size() && held_keys[lo] < rq.key)
                        lo++;
                    hi = lo;
                    while (hi < held_keys.size() && held_keys[hi] == rq.key)
                        hi++;
                    held_keys.insert(lo, rq.key);
                    o.want.position = CNT_W'(lo);
                    o.pos_hi = hi;
                end
            end
            CMD_REMOVE_KEY:
            begin
                lo = 0;
                while (lo < held_keys.size() && held_keys[lo] != rq.key)
                    lo++;
                if (lo == held_keys.size())
                    o.want.status = STATUS_NOT_FOUND;
                else
                begin
                    n = 0;
                    while (lo < held_keys.size() && held_keys[lo] == rq.key)
                    begin
                        held_keys.delete(lo);
                        n++;
                    end
                    o.want.position = CNT_W'(lo);
                    o.want.removed_count = CNT_W'(n);
                end
            end
            CMD_REMOVE_AT:
            begin
                if (int'(rq.index) >= held_keys.size())
                    o.want.status = STATUS_BAD_INDEX;
                else
                begin
                    held_keys.delete(int'(rq.index));
                    o.want.position = CNT_W'(rq.index);
                    o.want.removed_count = CNT_W'(1);
                end
            end
            default:
            begin
                o.want.removed_count = CNT_W'(held_keys.size());
                held_keys.delete();
            end
        endcase
        o.want.entry_count = CNT_W'(held_keys.size());
        if (o.pos_hi < 0)
            o.pos_hi = int'(o.want.position);
        return o;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_keys.delete();
            awaited_results.delete();
            fails = 0;
            checked = 0;
            full_hits = 0;
            miss_hits = 0;
            bad_index_hits = 0;
            peak_fill = 0;
            pending <= 0;
        end
        else
        begin
            // predict each accepted command
            if (request.valid && request.ready)
            begin
                awaited_results.push_back(apply_command(request.item));
                case (awaited_results[$].want.status)
                    STATUS_FULL:      full_hits++;
                    STATUS_NOT_FOUND: miss_hits++;
                    STATUS_BAD_INDEX: bad_index_hits++;
                    default:          ;
                endcase
                if (held_keys.size() > peak_fill)
                    peak_fill = held_keys.size();
            end

            // compare each accepted result with the oldest prediction
            if (response.valid && response.ready)
            begin
                if (awaited_results.size() == 0)
                    report_mismatch($sformatf("result with none expected (status %0d)",
                                              int'(response.item.status)));
                else
                begin
                    head = awaited_results.pop_front();
                    checked++;
                    if (response.item.status !== head.want.status)
                        report_mismatch($sformatf("status got %0d expected %0d",
                                                  int'(response.item.status),
                                                  int'(head.want.status)));
                    if ($isunknown(response.item.position)
                        || int'(response.item.position) < int'(head.want.position)
                        || int'(response.item.position) > head.pos_hi)
                        report_mismatch($sformatf("position got %0d expected %0d..%0d",
                                                  int'(response.item.position),
                                                  int'(head.want.position), head.pos_hi));
                    if (response.item.removed_count !== head.want.removed_count)
                        report_mismatch($sformatf("removed_count got %0d expected %0d",
                                                  int'(response.item.removed_count),
                                                  int'(head.want.removed_count)));
                    if (response.item.entry_count !== head.want.entry_count)
                        report_mismatch($sformatf("entry_count got %0d expected %0d",
                                                  int'(response.item.entry_count),
                                                  int'(head.want.entry_count)));
                end
            end
            pending <= awaited_results.size();
        end
    end

endmodule

@@ dv/tb.sv @@
module tb;
    import skt_pkg::*;

    localparam int N_ITEMS     = 1775;
    localparam int FILL_RUN    = 80;
    localparam int SETTLE      = 400;
    localparam int CYCLE_LIMIT = 3_000_000;

    // command mixes for the random rounds
    typedef enum int {
        MIX_GROW,
        MIX_SHRINK,
        MIX_EVEN,
        MIX_DUPS
    } mix_t;

    logic  clk = 1'b0;
    logic  rst_n = 1'b0;
    logic  calm = 1'b0;
    int    cycles = 0;
    int    sent = 0;

    logic [KEY_WIDTH-1:0]  key_pool[8];
    logic [KEY_WIDTH-1:0]  recent_keys[8];

    int  fails;
    int  pending;
    int  checked;
    int  full_hits;
    int  miss_hits;
    int  bad_index_hits;
    int  peak_fill;

    skt_req_if request();
    skt_rsp_if response();

    sorted_key_table dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .request  (request),
        .response (response)
    );

    sorted_table_checker table_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .request        (request),
        .response       (response),
        .fails          (fails),
        .pending        (pending),
        .checked        (checked),
        .full_hits      (full_hits),
        .miss_hits      (miss_hits),
        .bad_index_hits (bad_index_hits),
        .peak_fill      (peak_fill)
    );

    always #6 clk = ~clk;

    // result side: ready drops at random, about 9 times in a hundred, unless calm
    always @(posedge clk)
    begin
        if (!rst_n)
            response.ready <= 1'b0;
        else
            response.ready <= calm || ($urandom_range(99) >= 9);
    end

    // hang guard
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding", cycles, pending);
            $display("== FAIL ==");
            $finish;
        end
    end

    // keys mostly from a small pool so removals hit and duplicates pile up
    function automatic logic [KEY_WIDTH-1:0] pick_key();
        int r;
        r = $urandom_range(99);
        if (r < 40)
            return key_pool[$urandom_range(7)];
        else if (r < 60)
            return recent_keys[$urandom_range(7)];
        else
            return KEY_WIDTH'($urandom);
    endfunction

    function automatic logic [ADDR_W-1:0] pick_index();
        if ($urandom_range(1) == 0)
            return ADDR_W'($urandom_range(63));
        else
            return ADDR_W'($urandom_range(15));
    endfunction

    function automatic cmd_t choose_cmd(mix_t mix);
        int r;
        r = $urandom_range(99);
        case (mix)
            MIX_GROW:
                return r < 85 ? CMD_INSERT : r < 92 ? CMD_REMOVE_KEY
                     : r < 99 ? CMD_REMOVE_AT : CMD_CLEAR;
            MIX_SHRINK:
                return r < 25 ? CMD_INSERT : r < 62 ? CMD_REMOVE_KEY
                     : r < 99 ? CMD_REMOVE_AT : CMD_CLEAR;
            MIX_DUPS:
                return r < 65 ? CMD_INSERT : r < 95 ? CMD_REMOVE_KEY : CMD_REMOVE_AT;
            default:
                return r < 45 ? CMD_INSERT : r < 72 ? CMD_REMOVE_KEY
                     : r < 98 ? CMD_REMOVE_AT : CMD_CLEAR;
        endcase
    endfunction

    // offer one item and hold it until accepted; valid stays high afterwards
    task automatic send_cmd(cmd_t c, logic [KEY_WIDTH-1:0] k, logic [ADDR_W-1:0] ix);
        req_item_t it;
        it.command = c;
        it.key = k;
        it.index = ix;
        while (!calm && $urandom_range(99) < 9)
        begin
            request.valid <= 1'b0;
            @(posedge clk);
        end
        request.valid <= 1'b1;
        request.item <= it;
        @(posedge clk);
        while (!request.ready)
            @(posedge clk);
        if (c == CMD_INSERT)
            recent_keys[sent % 8] = k;
        sent++;
    endtask

    // stop sending until every outstanding result is back
    task automatic drain();
        request.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    initial
    begin
        mix_t                  mix;
        cmd_t                  c;
        logic [KEY_WIDTH-1:0]  k;
        int                    span;
        int                    round;

        request.valid = 1'b0;
        request.item = '0;
        response.ready = 1'b0;

        key_pool[0] = '0;
        key_pool[1] = '1;
        key_pool[2] = KEY_WIDTH'(32'h8000_0000);
        key_pool[3] = KEY_WIDTH'(32'h7fff_ffff);
        key_pool[4] = KEY_WIDTH'(1);
        for (int i = 5; i < 8; i++)
            key_pool[i] = KEY_WIDTH'($urandom);
        for (int i = 0; i < 8; i++)
            recent_keys[i] = key_pool[i];

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty table corner cases
        send_cmd(CMD_REMOVE_AT, '0, '0);
        send_cmd(CMD_REMOVE_KEY, '0, '0);
        send_cmd(CMD_CLEAR, '1, '1);
        // extremes and duplicate runs
        send_cmd(CMD_INSERT, KEY_WIDTH'(32'h8000_0000), '0);
        send_cmd(CMD_INSERT, '0, '1);
        send_cmd(CMD_INSERT, '1, '0);
        send_cmd(CMD_INSERT, '0, '0);
        send_cmd(CMD_INSERT, KEY_WIDTH'(32'h7fff_ffff), '0);
        send_cmd(CMD_INSERT, '0, '0);
        send_cmd(CMD_INSERT, '1, '0);
        // remove a run of three, then the key is gone
        send_cmd(CMD_REMOVE_KEY, '0, '0);
        send_cmd(CMD_REMOVE_KEY, '0, '0);
        // index out of range, at the count, then last and first
        send_cmd(CMD_REMOVE_AT, '0, '1);
        send_cmd(CMD_REMOVE_AT, '0, ADDR_W'(4));
        send_cmd(CMD_REMOVE_AT, '0, ADDR_W'(3));
        send_cmd(CMD_REMOVE_AT, '1, '0);
        send_cmd(CMD_INSERT, KEY_WIDTH'(1), '0);
        send_cmd(CMD_REMOVE_KEY, KEY_WIDTH'(32'h1234_5678), '0);
        send_cmd(CMD_REMOVE_KEY, '1, '0);
        send_cmd(CMD_INSERT, KEY_WIDTH'(32'h5555_5555), ADDR_W'(6'h2a));
        send_cmd(CMD_INSERT, KEY_WIDTH'(32'haaaa_aaaa), ADDR_W'(6'h15));
        send_cmd(CMD_CLEAR, '0, '0);
        drain();

        // fill past capacity so full-table inserts are rejected
        for (int i = 0; i < FILL_RUN; i++)
            send_cmd(CMD_INSERT, pick_key(), pick_index());

        // random rounds of varying command mix
        round = 0;
        while (sent < N_ITEMS)
        begin
            mix = mix_t'($urandom_range(3));
            calm <= (round == 2);
            span = (round == 2) ? 200 : $urandom_range(40, 120);
            for (int i = 0; i < span && sent < N_ITEMS; i++)
            begin
                c = choose_cmd(mix);
                k = (mix == MIX_DUPS) ? key_pool[$urandom_range(2)] : pick_key();
                send_cmd(c, k, pick_index());
            end
            if ($urandom_range(3) == 0)
                drain();
            if ($urandom_range(6) == 0)
                send_cmd(CMD_CLEAR, pick_key(), pick_index());
            round++;
        end

        // wind down
        request.valid <= 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);

        $display("%0d commands sent, %0d results checked, table peaked at %0d keys",
                 sent, checked, peak_fill);
        $display("rejections seen: %0d full, %0d absent key, %0d bad index",
                 full_hits, miss_hits, bad_index_hits);
        if (fails == 0 && pending == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

@@ filelist.f @@
sv/skt_pkg.sv
sv/skt_channels.sv
sv/sorted_key_table.sv
dv/sorted_table_checker.sv
dv/tb.sv
